FILE: rtl/kse_pkg.sv
// shared types and codes for the keyed stack engine
`default_nettype none
package kse_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned KEY_W = 32;

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_CLEAR  = 3'd4
  } kse_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } kse_status_t;

  // per-step controls broadcast to every cell
  typedef struct packed {
    logic             push_en;
    logic             delete_en;
    logic             insert_en;
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] search_key;
  } kse_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/kse_req_if.sv
// request channel: command, key and search key
`default_nettype none
interface kse_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [31:0] value;
  logic signed [31:0] search_key;

  modport source (output valid, output kind, output value, output search_key, input ready);
  modport sink (input valid, input kind, input value, input search_key, output ready);
endinterface
`default_nettype wire

FILE: rtl/kse_rsp_if.sv
// response channel: top key, status and entry count
`default_nettype none
interface kse_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  modport source (output valid, output top_value, output status, output entry_count, input ready);
  modport sink (input valid, input top_value, input status, input entry_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/kse_cell.sv
// one stack slot: key storage, match compare, shift and read chain
`default_nettype none
module kse_cell #(
  parameter int unsigned DEPTH = kse_pkg::DEPTH_DEFAULT,
  parameter int unsigned INDEX = 0,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  kse_pkg::kse_ctl_t       ctl,
  input  logic [CW-1:0]           count,
  input  logic [IW-1:0]           rd_idx,
  input  logic                    ge_above,
  input  logic                    ge_below,
  input  logic [kse_pkg::KEY_W-1:0] up_entry,
  input  logic [kse_pkg::KEY_W-1:0] down_entry,
  input  logic [kse_pkg::KEY_W-1:0] rd_in,
  output logic                    ge,
  output logic [kse_pkg::KEY_W-1:0] entry,
  output logic [kse_pkg::KEY_W-1:0] rd_out
);
  import kse_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(INDEX);
  localparam logic [IW-1:0] IDX_I = IW'(INDEX);

  logic occupied;
  logic match;

  assign occupied = IDX_C < count;
  assign match    = occupied && (entry == ctl.search_key);
  // a match here or anywhere above: this slot is at or below the first match
  assign ge       = match | ge_above;

  always_ff @(posedge clk) begin
    if (ctl.push_en && (count == IDX_C)) begin
      entry <= ctl.value;
    end else if (ctl.delete_en && !ge_above) begin
      entry <= up_entry;
    end else if (ctl.insert_en) begin
      if (!ge_below) begin
        entry <= down_entry;
      end else if (!ge) begin
        entry <= ctl.value;
      end
    end
  end

  assign rd_out = rd_in | ((rd_idx == IDX_I) ? entry : '0);

endmodule
`default_nettype wire

FILE: rtl/keyed_stack_engine.sv
// keyed stack engine top level: command sequencer over a chain of key cells
// sequence: request accepted, the cell chain shifts in the execute step, the top key is
//   read through the read chain in the read step, then the response is registered
// flow: a new request is taken only when idle and the response register is free
// reset: rst (synchronous) empties the stack and drops any pending response;
//   key storage itself is not cleared
`default_nettype none
module keyed_stack_engine #(
  parameter int unsigned DEPTH = kse_pkg::DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  kse_req_if.sink  req,
  kse_rsp_if.source rsp
);
  import kse_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // latched request
  logic [2:0]       kind;
  logic [KEY_W-1:0] value;
  logic [KEY_W-1:0] search_key;

  // stack fill level
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    count_m1;

  // step results held for the read cycle
  kse_status_t      status;
  kse_status_t      status_next;
  logic [IW-1:0]    rd_idx;
  logic             show_none;

  // response register
  logic             out_valid;
  logic [KEY_W-1:0] out_top;
  kse_status_t      out_status;
  logic [4:0]       out_count;

  logic             accept;
  logic             full;
  logic             empty;
  logic             found;
  logic             is_pop;
  kse_ctl_t         ctl;

  // cell chain wiring
  logic [KEY_W-1:0] ent [DEPTH];
  logic [KEY_W-1:0] rd  [DEPTH];
  logic             ge  [DEPTH];

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  assign full   = (count == DEPTH_C);
  assign empty  = (count == '0);
  // bottom of the match chain: some occupied slot matched the search key
  assign found  = ge[0];
  assign is_pop = (kind == KIND_POP);

  // controls only fire in the execute cycle
  always_comb begin
    ctl            = '0;
    ctl.value      = value;
    ctl.search_key = search_key;
    if (state == S_EXEC) begin
      ctl.push_en   = (kind == KIND_PUSH) && !full;
      ctl.delete_en = (kind == KIND_DELETE) && found;
      // insert with no match lands at the bottom, same path as an empty stack
      ctl.insert_en = (kind == KIND_INSERT) && !full;
    end
  end

  // new fill level and status of this step
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      KIND_DELETE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - CW'(1);
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          if (!empty && !found) begin
            status_next = ST_NOT_FOUND;
          end
        end
      end
      KIND_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_m1 = count_next - CW'(1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        count <= count_next;
      end
      if (state == S_RESP) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind       <= req.kind;
      value      <= req.value;
      search_key <= req.search_key;
    end
    if (state == S_EXEC) begin
      status <= status_next;
      // a popped key still sits in the slot just above the new top
      if (is_pop) begin
        show_none <= empty;
        rd_idx    <= count_next[IW-1:0];
      end else begin
        show_none <= (count_next == '0);
        rd_idx    <= count_m1[IW-1:0];
      end
    end
    if (state == S_RESP) begin
      out_top    <= show_none ? '1 : rd[0];
      out_status <= status;
      out_count  <= 5'(count);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.top_value   = out_top;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

  // row of cells: index 0 is the bottom of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             ge_above;
    logic             ge_below;
    logic [KEY_W-1:0] up_entry;
    logic [KEY_W-1:0] down_entry;
    logic [KEY_W-1:0] rd_in;

    if (i == DEPTH - 1) begin : g_top
      assign ge_above = 1'b0;
      assign up_entry = '0;
      assign rd_in    = '0;
    end else begin : g_mid
      assign ge_above = ge[i+1];
      assign up_entry = ent[i+1];
      assign rd_in    = rd[i+1];
    end

    if (i == 0) begin : g_bot
      assign ge_below   = 1'b1;
      assign down_entry = '0;
    end else begin : g_up
      assign ge_below   = ge[i-1];
      assign down_entry = ent[i-1];
    end

    kse_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .rd_idx     (rd_idx),
      .ge_above   (ge_above),
      .ge_below   (ge_below),
      .up_entry   (up_entry),
      .down_entry (down_entry),
      .rd_in      (rd_in),
      .ge         (ge[i]),
      .entry      (ent[i]),
      .rd_out     (rd[i])
    );
  end

`ifndef SYNTHESIS
  // fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stack count above depth");

  // an accepted request always goes to execute next
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted request did not execute");

  // execute is always followed by the read step
  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_RESP))
    else $error("execute not followed by read");

  // the response register is free when a new response is loaded
  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> !out_valid)
    else $error("response overwritten");

  // a response appears right after the read step
  a_resp_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |=> rsp.valid)
    else $error("response missing after read");
`endif

endmodule
`default_nettype wire
